// ----- rtl/core/noise_level_tracker_macros.svh -----
// Assertion macros for the noise level tracker.
// Included by the top level; no other dependencies.
`ifndef NOISE_LEVEL_TRACKER_MACROS_SVH
`define NOISE_LEVEL_TRACKER_MACROS_SVH

// same-cycle implication
`define NLT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/nlt_pkg.sv -----
// Shared types and constants for the noise level tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package nlt_pkg;

   localparam int COUNT_BITS_DEFAULT = 24;

   localparam int MV_W       = 12;
   localparam int RAW_W      = 10;
   localparam int TIME_W     = 32;
   localparam int CYC_W      = 7;
   localparam int Q_W        = 12;
   localparam int STEP_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 96;
   localparam int RECIP_W    = 34;
   localparam int PROD_W     = RAW_W + RECIP_W;

   // raw * 3300 / 1023 == (raw * RECIP) >> 32, exact for 10-bit raw
   localparam logic [RECIP_W-1:0] MV_SCALE_RECIP = 34'd13854736500;

   localparam logic [MV_W-1:0]   OUTLIER_RESET   = 12'd3300;
   localparam logic [MV_W-1:0]   INIT_LOW_RESET  = 12'd3300;
   localparam logic [TIME_W-1:0] LEGAL_RESET     = 32'd60000;
   localparam logic [TIME_W-1:0] DUTY_RESET      = 32'd1000;
   localparam logic [TIME_W-1:0] UPDATE_RESET    = 32'd1000;
   localparam logic [TIME_W-1:0] SECOND_MS       = 32'd1000;
   localparam logic [MV_W-1:0]   MIN_RESET       = 12'd1000;
   localparam logic [CYC_W-1:0]  CYCLE_START     = 7'd50;
   localparam logic [CYC_W-1:0]  CYCLE_TOP       = 7'd99;
   localparam int                WARMUP_SAMPLES  = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_OUTLIER_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_LOW_LEVEL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEGAL_PERIOD_MS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_CYCLE_MS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_INTERVAL_MS = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_UPDATE,
      ST_LEGAL_CHECK,
      ST_LEGAL_WAIT,
      ST_DUTY_CHECK,
      ST_DUTY_WAIT,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic in_ready;
      logic scale;
      logic update;
      logic div_start;
      logic div_sel_legal;
      logic legal_close;
      logic finish;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic legal_end;
      logic duty_divide;
      logic div_done;
      logic div_busy;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/noise_level_tracker.sv -----
// Noise level tracker. Each request word carries a 10-bit converter reading, the
// millisecond time and a flag-clear request; each yields one response word with the
// reading in mV and the running statistics after it. The next word is accepted only
// after this one has passed scale, update and the result register, and a division
// when the legal window closes and one when the duty cycle ends; the next word waits
// longer while the previous response word is still waiting. Both divisions share one
// divider that forms a bit per cycle.
// The response register holds a finished word while the next request is taken.
// Configuration writes are taken at any time; apply them while no word is in flight.
// Depends on nlt_pkg, nlt_ctrl, nlt_datapath, nlt_divider and the macros header.
`default_nettype none

`include "noise_level_tracker_macros.svh"

module noise_level_tracker
   import nlt_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [9:0] adc_raw, [41:10] now_ms, [42] reset_request, [47:43] zero
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [11:0] noise_mv, [23:12] average_mv, [35:24] peak_mv, [47:36] minimum_mv,
   // [59:48] legal_average_mv, [71:60] legal_maximum_mv, [83:72] low_level_mv,
   // [90:84] cycle_count, [91] data_ready, [92] cycle_complete, [95:93] zero
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   nlt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   nlt_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   assign req_tready = cmd.in_ready;

   `NLT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready,
                    "second word accepted while one is in flight")
   `NLT_ASSERT_NOW(a_div_start_idle, clock, reset, cmd.div_start, !status.div_busy,
                   "divider restarted while busy")
   `NLT_ASSERT_NOW(a_rsp_from_load, clock, reset, $rose(rsp_tvalid), $past(cmd.out_load),
                   "response raised without a load")
   `NLT_ASSERT_NOW(a_cycle_range, clock, reset, rsp_tvalid, rsp_tdata[90:84] <= 7'd100,
                   "cycle count out of range")

endmodule

`default_nettype wire

// ----- rtl/core/nlt_divider.sv -----
// Restoring divider, one quotient bit per cycle, 12-bit quotient.
// Depends on nlt_pkg; dividend must be below 4096 times the divisor.
`default_nettype none

module nlt_divider
   import nlt_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [COUNT_BITS+MV_W-1:0]   dividend,
   input  wire logic [COUNT_BITS-1:0]        divisor,
   output logic                              busy,
   output logic                              done,
   output logic [Q_W-1:0]                    quotient
);

   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] divisor_ff, divisor_in;
   logic [Q_W-1:0]        quo_ff, quo_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS:0]   shifted;
   logic [COUNT_BITS:0]   diff;
   logic                  fits;

   assign shifted = {rem_ff, quo_ff[Q_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = ~diff[COUNT_BITS];

   always_comb begin
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         // upper bits are already below the divisor
         rem_in     = dividend[COUNT_BITS+MV_W-1:Q_W];
         quo_in     = dividend[Q_W-1:0];
         divisor_in = divisor;
         step_in    = STEP_W'(Q_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
         quo_in  = {quo_ff[Q_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/core/nlt_ctrl.sv -----
// Sequencer for the noise level tracker: walks one word through scale,
// update, the two divisions and the result register. Depends on nlt_pkg.
`default_nettype none

module nlt_ctrl
   import nlt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_LEGAL_CHECK;
         end
         ST_LEGAL_CHECK: begin
            if (status.legal_end) begin
               cmd.div_start     = 1'b1;
               cmd.div_sel_legal = 1'b1;
               state_in          = ST_LEGAL_WAIT;
            end else begin
               state_in = ST_DUTY_CHECK;
            end
         end
         ST_LEGAL_WAIT: begin
            if (status.div_done) begin
               cmd.legal_close = 1'b1;
               state_in        = ST_DUTY_CHECK;
            end
         end
         ST_DUTY_CHECK: begin
            if (status.duty_divide) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DUTY_WAIT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DUTY_WAIT: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/nlt_datapath.sv -----
// Datapath for the noise level tracker: config registers, statistics state,
// scaling multiplier, shared divider and result register. Depends on nlt_pkg.
`default_nettype none

module nlt_datapath
   import nlt_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic                   req_tvalid,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SUM_W = COUNT_BITS + MV_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // configuration
   logic [MV_W-1:0]   outlier_ff;
   logic [TIME_W-1:0] legal_period_ff, duty_ff, update_ff;

   // captured word
   logic [RAW_W-1:0]  raw_ff, raw_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic              rst_req_ff, rst_req_in;
   logic [MV_W-1:0]   noise_ff, noise_in;
   logic              second_fire_ff, second_fire_in;
   logic              legal_fire_ff, legal_fire_in;
   logic              duty_fire_ff, duty_fire_in;
   logic              update_fire_ff, update_fire_in;
   logic              legal_end_ff, legal_end_in;

   // statistics state
   logic [MV_W-1:0]       low_ff, low_in;
   logic [TIME_W-1:0]     second_mark_ff, second_mark_in;
   logic [TIME_W-1:0]     legal_mark_ff, legal_mark_in;
   logic [TIME_W-1:0]     cycle_mark_ff, cycle_mark_in;
   logic [TIME_W-1:0]     update_mark_ff, update_mark_in;
   logic [SUM_W-1:0]      second_sum_ff, second_sum_in;
   logic [COUNT_BITS-1:0] second_count_ff, second_count_in;
   logic [SUM_W-1:0]      legal_sum_ff, legal_sum_in;
   logic [COUNT_BITS-1:0] legal_count_ff, legal_count_in;
   logic [MV_W-1:0]       average_ff, average_in;
   logic [MV_W-1:0]       legal_avg_ff, legal_avg_in;
   logic [MV_W-1:0]       legal_max_ff, legal_max_in;
   logic [MV_W-1:0]       peak_ff, peak_in;
   logic [MV_W-1:0]       minimum_ff, minimum_in;
   logic [CYC_W-1:0]      cycle_ff, cycle_in;
   logic                  dir_up_ff, dir_up_in;
   logic                  done_flag_ff, done_flag_in;
   logic                  ready_flag_ff, ready_flag_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [PROD_W-1:0]     scale_prod;
   logic [TIME_W-1:0]     second_age, legal_age, cycle_age, update_age;
   logic                  accepted;
   logic [COUNT_BITS-1:0] second_count_next;
   logic                  dir_next;
   logic                  done_next;

   logic [SUM_W-1:0]      div_dividend;
   logic [COUNT_BITS-1:0] div_divisor;
   logic                  div_busy, div_done;
   logic [Q_W-1:0]        div_q;

   assign div_dividend = cmd.div_sel_legal ? legal_sum_ff : second_sum_ff;
   assign div_divisor  = cmd.div_sel_legal ? legal_count_ff : second_count_ff;

   nlt_divider #(
      .COUNT_BITS (COUNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         outlier_ff      <= OUTLIER_RESET;
         legal_period_ff <= LEGAL_RESET;
         duty_ff         <= DUTY_RESET;
         update_ff       <= UPDATE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OUTLIER_THRESHOLD:  outlier_ff      <= csr_wdata[MV_W-1:0];
            // start values only matter at reset, which restores the default
            CSR_INITIAL_LOW_LEVEL:  ;
            CSR_LEGAL_PERIOD_MS:    legal_period_ff <= csr_wdata;
            CSR_DUTY_CYCLE_MS:      duty_ff         <= csr_wdata;
            CSR_UPDATE_INTERVAL_MS: update_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign scale_prod = PROD_W'(raw_ff) * PROD_W'(MV_SCALE_RECIP);
   assign second_age = now_ff - second_mark_ff;
   assign legal_age  = now_ff - legal_mark_ff;
   assign cycle_age  = now_ff - cycle_mark_ff;
   assign update_age = now_ff - update_mark_ff;
   assign accepted   = (noise_ff <= outlier_ff);
   assign second_count_next = (second_fire_ff && second_count_ff != COUNT_MAX)
                            ? second_count_ff + COUNT_BITS'(1) : second_count_ff;

   always_comb begin
      raw_in          = raw_ff;
      now_in          = now_ff;
      rst_req_in      = rst_req_ff;
      noise_in        = noise_ff;
      second_fire_in  = second_fire_ff;
      legal_fire_in   = legal_fire_ff;
      duty_fire_in    = duty_fire_ff;
      update_fire_in  = update_fire_ff;
      legal_end_in    = legal_end_ff;
      low_in          = low_ff;
      second_mark_in  = second_mark_ff;
      legal_mark_in   = legal_mark_ff;
      cycle_mark_in   = cycle_mark_ff;
      update_mark_in  = update_mark_ff;
      second_sum_in   = second_sum_ff;
      second_count_in = second_count_ff;
      legal_sum_in    = legal_sum_ff;
      legal_count_in  = legal_count_ff;
      average_in      = average_ff;
      legal_avg_in    = legal_avg_ff;
      legal_max_in    = legal_max_ff;
      peak_in         = peak_ff;
      minimum_in      = minimum_ff;
      cycle_in        = cycle_ff;
      dir_up_in       = dir_up_ff;
      done_flag_in    = done_flag_ff;
      ready_flag_in   = ready_flag_ff;
      dir_next        = dir_up_ff;
      done_next       = done_flag_ff;

      if (cmd.in_ready && req_tvalid) begin
         raw_in     = req_tdata[RAW_W-1:0];
         now_in     = req_tdata[RAW_W+TIME_W-1:RAW_W];
         rst_req_in = req_tdata[RAW_W+TIME_W];
      end

      if (cmd.scale) begin
         noise_in       = scale_prod[PROD_W-1:PROD_W-MV_W];
         second_fire_in = (second_age > SECOND_MS);
         legal_fire_in  = (legal_age > legal_period_ff);
         duty_fire_in   = (cycle_age > duty_ff);
         update_fire_in = (update_age >= update_ff);
      end

      if (cmd.update) begin
         legal_end_in = accepted & legal_fire_ff;
         if (accepted) begin
            if (noise_ff < low_ff) begin
               low_in = noise_ff;
            end
            if (second_fire_ff) begin
               if (second_count_ff != COUNT_MAX) begin
                  second_sum_in   = second_sum_ff + SUM_W'(noise_ff);
                  second_count_in = second_count_next;
               end
               second_mark_in = now_ff;
            end
            if (legal_count_ff != COUNT_MAX) begin
               legal_sum_in   = legal_sum_ff + SUM_W'(noise_ff);
               legal_count_in = legal_count_ff + COUNT_BITS'(1);
            end
            if (legal_fire_ff) begin
               legal_mark_in = now_ff;
            end
            if (noise_ff > peak_ff) begin
               peak_in = noise_ff;
            end
            if (noise_ff < minimum_ff && second_count_next > COUNT_BITS'(WARMUP_SAMPLES)) begin
               minimum_in = noise_ff;
            end
         end
      end

      if (cmd.legal_close) begin
         if (legal_count_ff != '0) begin
            legal_avg_in = div_q;
            if (div_q > legal_max_ff) begin
               legal_max_in = div_q;
            end
         end
         legal_sum_in   = '0;
         legal_count_in = '0;
      end

      if (cmd.finish) begin
         if (rst_req_ff) begin
            done_next = 1'b0;
         end
         if (duty_fire_ff) begin
            cycle_mark_in = now_ff;
            if (second_count_ff != '0) begin
               average_in = div_q;
            end
            if (cycle_ff > CYCLE_TOP) begin
               dir_next = 1'b0;
            end else if (cycle_ff == '0) begin
               low_in   = minimum_ff;
               dir_next = 1'b1;
            end
            dir_up_in       = dir_next;
            cycle_in        = dir_next ? cycle_ff + CYC_W'(1) : cycle_ff - CYC_W'(1);
            second_sum_in   = '0;
            second_count_in = '0;
            done_next       = 1'b1;
         end
         if (update_fire_ff) begin
            update_mark_in = now_ff;
            ready_flag_in  = 1'b1;
            done_next      = 1'b0;
         end
         done_flag_in = done_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, done_flag_ff, ready_flag_ff, cycle_ff, low_ff,
                         legal_max_ff, legal_avg_ff, minimum_ff, peak_ff,
                         average_ff, noise_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         legal_end_ff    <= 1'b0;
         low_ff          <= INIT_LOW_RESET;
         second_mark_ff  <= '0;
         legal_mark_ff   <= '0;
         cycle_mark_ff   <= '0;
         update_mark_ff  <= '0;
         second_sum_ff   <= '0;
         second_count_ff <= '0;
         legal_sum_ff    <= '0;
         legal_count_ff  <= '0;
         average_ff      <= INIT_LOW_RESET;
         legal_avg_ff    <= INIT_LOW_RESET;
         legal_max_ff    <= INIT_LOW_RESET;
         peak_ff         <= '0;
         minimum_ff      <= MIN_RESET;
         cycle_ff        <= CYCLE_START;
         dir_up_ff       <= 1'b1;
         done_flag_ff    <= 1'b0;
         ready_flag_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         legal_end_ff    <= legal_end_in;
         low_ff          <= low_in;
         second_mark_ff  <= second_mark_in;
         legal_mark_ff   <= legal_mark_in;
         cycle_mark_ff   <= cycle_mark_in;
         update_mark_ff  <= update_mark_in;
         second_sum_ff   <= second_sum_in;
         second_count_ff <= second_count_in;
         legal_sum_ff    <= legal_sum_in;
         legal_count_ff  <= legal_count_in;
         average_ff      <= average_in;
         legal_avg_ff    <= legal_avg_in;
         legal_max_ff    <= legal_max_in;
         peak_ff         <= peak_in;
         minimum_ff      <= minimum_in;
         cycle_ff        <= cycle_in;
         dir_up_ff       <= dir_up_in;
         done_flag_ff    <= done_flag_in;
         ready_flag_ff   <= ready_flag_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff         <= raw_in;
      now_ff         <= now_in;
      rst_req_ff     <= rst_req_in;
      noise_ff       <= noise_in;
      second_fire_ff <= second_fire_in;
      legal_fire_ff  <= legal_fire_in;
      duty_fire_ff   <= duty_fire_in;
      update_fire_ff <= update_fire_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign status.legal_end   = legal_end_ff;
   assign status.duty_divide = duty_fire_ff & (second_count_ff != '0);
   assign status.div_done    = div_done;
   assign status.div_busy    = div_busy;
   assign status.out_busy    = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
